// ===== rtl/abd_pkg.sv =====
// Shared types, constants and register indexes for the ladder keypad decoder.
// Depends on nothing; every other file of the block imports it.
package abd_pkg;

    // Upper bound on the number of ladder windows the block can hold.
    localparam int MAX_BUTTONS = 3;

    // Defaults for the top level parameters.
    localparam int NUM_BUTTONS_DEF          = 3;
    localparam int RELEASE_SCANS_NEEDED_DEF = 3;
    localparam int MIN_PRESS_MS_DEF         = 100;

    // A failed read is decoded as a full-scale sample.
    localparam logic [11:0] FAILED_SAMPLE = 12'hFFF;

    // Reset values of the timing registers.
    localparam logic [15:0] LONG_PRESS_RESET   = 16'd2000;
    localparam logic [15:0] DOUBLE_CLICK_RESET = 16'd300;

    // Scan queue between classifier and press tracker.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LOW_A   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_HIGH_A  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LOW_B   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_HIGH_B  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LOW_C   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_HIGH_C  = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_LONG_PRESS_MS  = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_DOUBLE_CLICK_MS = 3'd7;

    localparam int CFG_DATA_W = 16;

    // One sample window.
    typedef struct packed {
        logic [11:0] low;
        logic [11:0] high;
    } window_t;

    // Timing thresholds used by the press tracker.
    typedef struct packed {
        logic [15:0] long_press_ms;
        logic [15:0] double_click_ms;
    } timing_t;

    // A classified scan as it travels through the queue.
    typedef struct packed {
        logic [1:0]  button;
        logic [31:0] now_ms;
    } scan_t;

    // Queue occupancy seen by the front end and by the top level checks.
    typedef struct packed {
        logic                   full;
        logic                   empty;
        logic [QUEUE_CNT_W-1:0] count;
    } queue_status_t;

endpackage

// ===== rtl/adc_ladder_button_decoder.sv =====
// Top level of the resistor ladder keypad decoder: configuration registers,
// classifier front end, scan queue and press tracker. Depends on abd_pkg.
//
// Usage. Each scan is one transaction on the input channel (in_valid,
// in_stall, adc_sample, sample_ok, now_ms); it is taken at a rising edge with
// in_valid high and in_stall low. The front end matches the sample against
// the button windows (lowest numbered window first, a failed read counting as
// full scale) and writes the button number and timestamp into a two-entry
// queue. The press tracker takes one scan per cycle from the queue, unless the
// output is stalled, and loads exactly one result transaction (event_button
// and the four flags) into the output register, handed over when out_valid is
// high and out_stall is low. An accepted scan passes through a queue entry
// and then the output register. When the receiver stalls, the result is held,
// the queue fills, and in_stall rises once both queue entries are occupied.
// Reset (rst_n low, asynchronous) empties the queue and the result stage,
// clears the press state and loads the register defaults: all windows 0,
// long press 2000 ms, double click gap 300 ms. The configuration channel
// (cfg_valid, cfg_ready, cfg_index, cfg_data) is always ready and should be
// written only while no scan is in flight.
module adc_ladder_button_decoder
    import abd_pkg::*;
#(
    parameter int NUM_BUTTONS          = NUM_BUTTONS_DEF,
    parameter int RELEASE_SCANS_NEEDED = RELEASE_SCANS_NEEDED_DEF,
    parameter int MIN_PRESS_MS         = MIN_PRESS_MS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [11:0]            adc_sample,
    input  logic                   sample_ok,
    input  logic [31:0]            now_ms,

    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [1:0]             event_button,
    output logic                   short_press,
    output logic                   long_press,
    output logic                   double_click,
    output logic                   press_aborted,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    window_t       windows_reg [MAX_BUTTONS];
    timing_t       timing_reg;
    logic          cfg_write;

    logic          push;
    scan_t         push_scan;
    logic          pop;
    scan_t         head_scan;
    queue_status_t q_status;

    // The register file never back-pressures.
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_BUTTONS; k++)
            begin
                windows_reg[k] <= '0;
            end
            timing_reg.long_press_ms   <= LONG_PRESS_RESET;
            timing_reg.double_click_ms <= DOUBLE_CLICK_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_WINDOW_LOW_A:    windows_reg[0].low  <= cfg_data[11:0];
                REG_WINDOW_HIGH_A:   windows_reg[0].high <= cfg_data[11:0];
                REG_WINDOW_LOW_B:    windows_reg[1].low  <= cfg_data[11:0];
                REG_WINDOW_HIGH_B:   windows_reg[1].high <= cfg_data[11:0];
                REG_WINDOW_LOW_C:    windows_reg[2].low  <= cfg_data[11:0];
                REG_WINDOW_HIGH_C:   windows_reg[2].high <= cfg_data[11:0];
                REG_LONG_PRESS_MS:   timing_reg.long_press_ms   <= cfg_data;
                REG_DOUBLE_CLICK_MS: timing_reg.double_click_ms <= cfg_data;
                default:             ;
            endcase
        end
    end

    abd_front #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_front (
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .adc_sample (adc_sample),
        .sample_ok  (sample_ok),
        .now_ms     (now_ms),
        .windows    (windows_reg),
        .q_status   (q_status),
        .push       (push),
        .push_scan  (push_scan)
    );

    abd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_scan (push_scan),
        .pop       (pop),
        .head_scan (head_scan),
        .status    (q_status)
    );

    abd_back #(
        .RELEASE_SCANS_NEEDED (RELEASE_SCANS_NEEDED),
        .MIN_PRESS_MS         (MIN_PRESS_MS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_status.empty),
        .head_scan     (head_scan),
        .pop           (pop),
        .timing        (timing_reg),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .event_button  (event_button),
        .short_press   (short_press),
        .long_press    (long_press),
        .double_click  (double_click),
        .press_aborted (press_aborted)
    );

`ifndef SYNTHESIS
    // The queue only ever pushes back once both entries hold scans.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (q_status.count == QUEUE_CNT_W'(QUEUE_DEPTH)))
        else $error("input stalled while the scan queue has room");

    // At most one kind of event per result.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot0({short_press, long_press, press_aborted}))
        else $error("more than one event kind in one result");

    // A double click is always the completion of a short press.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && double_click) |-> short_press)
        else $error("double click without a short press");

    // A button number is reported exactly when some event is reported.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((event_button != 2'd0) == (short_press || long_press || press_aborted)))
        else $error("event button does not agree with the event flags");
`endif

endmodule

// ===== rtl/abd_front.sv =====
// Front end: takes scan transactions and maps the sample onto a button number.
// Depends on abd_pkg for window_t, scan_t and queue_status_t.
module abd_front
    import abd_pkg::*;
#(
    parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
)
(
    input  logic          in_valid,
    output logic          in_stall,
    input  logic [11:0]   adc_sample,
    input  logic          sample_ok,
    input  logic [31:0]   now_ms,
    input  window_t       windows [MAX_BUTTONS],
    input  queue_status_t q_status,
    output logic          push,
    output scan_t         push_scan
);

    logic [11:0] sample;
    logic [1:0]  button;

    assign sample = sample_ok ? adc_sample : FAILED_SAMPLE;

    // Walk the windows from the highest number down so the lowest match wins.
    always_comb
    begin
        button = 2'd0;
        for (int k = MAX_BUTTONS - 1; k >= 0; k--)
        begin
            if (k < NUM_BUTTONS && sample >= windows[k].low && sample <= windows[k].high)
            begin
                button = 2'(k + 1);
            end
        end
    end

    assign in_stall         = q_status.full;
    assign push             = in_valid && !q_status.full;
    assign push_scan.button = button;
    assign push_scan.now_ms = now_ms;

endmodule

// ===== rtl/abd_queue.sv =====
// Short scan queue that decouples the classifier from the press tracker.
// Depends on abd_pkg for scan_t, queue_status_t and the queue sizing.
module abd_queue
    import abd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  scan_t         push_scan,
    input  logic          pop,
    output scan_t         head_scan,
    output queue_status_t status
);

    scan_t                  mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;

    function automatic logic [QUEUE_PTR_W-1:0] ptr_inc(input logic [QUEUE_PTR_W-1:0] p);
        logic [QUEUE_PTR_W-1:0] r;
        if (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_scan;
        end
    end

    assign head_scan    = mem_reg[rd_ptr_reg];
    assign status.full  = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign status.count = count_reg;

endmodule

// ===== rtl/abd_back.sv =====
// Back end: press, release, long press and double click tracking, with the
// registered result stage. Depends on abd_pkg for scan_t and timing_t.
module abd_back
    import abd_pkg::*;
#(
    parameter int RELEASE_SCANS_NEEDED = RELEASE_SCANS_NEEDED_DEF,
    parameter int MIN_PRESS_MS         = MIN_PRESS_MS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_empty,
    input  scan_t       head_scan,
    output logic        pop,
    input  timing_t     timing,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  event_button,
    output logic        short_press,
    output logic        long_press,
    output logic        double_click,
    output logic        press_aborted
);

    logic        pressed_reg, pressed_next;
    logic [1:0]  held_reg, held_next;
    logic [31:0] start_reg, start_next;
    logic [1:0]  release_reg, release_next;
    logic [31:0] click_time_reg, click_time_next;
    logic [1:0]  click_button_reg, click_button_next;
    logic [1:0]  tally_reg, tally_next;

    logic        out_valid_reg, out_valid_next;
    logic [1:0]  ev_reg, ev_next;
    logic        sp_reg, sp_next;
    logic        lp_reg, lp_next;
    logic        dc_reg, dc_next;
    logic        ab_reg, ab_next;

    logic [31:0] hold_time;
    logic [31:0] click_gap;
    logic [1:0]  release_count;
    logic [1:0]  tally_inc;

    // A scan leaves the queue whenever the result slot is free or being emptied.
    assign pop = !q_empty && (!out_valid_reg || !out_stall);

    assign hold_time     = head_scan.now_ms - start_reg;
    assign click_gap     = head_scan.now_ms - click_time_reg;
    assign release_count = release_reg + 1'b1;
    assign tally_inc     = tally_reg + 1'b1;

    always_comb
    begin
        pressed_next      = pressed_reg;
        held_next         = held_reg;
        start_next        = start_reg;
        release_next      = release_reg;
        click_time_next   = click_time_reg;
        click_button_next = click_button_reg;
        tally_next        = tally_reg;
        ev_next           = 2'd0;
        sp_next           = 1'b0;
        lp_next           = 1'b0;
        dc_next           = 1'b0;
        ab_next           = 1'b0;

        if (head_scan.button != 2'd0 && !pressed_reg)
        begin
            held_next    = head_scan.button;
            start_next   = head_scan.now_ms;
            pressed_next = 1'b1;
            release_next = 2'd0;
        end
        else if (head_scan.button == 2'd0 && pressed_reg)
        begin
            release_next = release_count;
            if (release_count >= 2'(RELEASE_SCANS_NEEDED))
            begin
                if (hold_time >= 32'(MIN_PRESS_MS) && hold_time < {16'd0, timing.long_press_ms})
                begin
                    ev_next = held_reg;
                    sp_next = 1'b1;
                    if (click_gap < {16'd0, timing.double_click_ms}
                        && click_button_reg == held_reg)
                    begin
                        tally_next = tally_inc;
                        if (tally_inc == 2'd2)
                        begin
                            dc_next    = 1'b1;
                            tally_next = 2'd0;
                        end
                    end
                    else
                    begin
                        tally_next = 2'd1;
                    end
                    click_time_next   = head_scan.now_ms;
                    click_button_next = held_reg;
                end
                pressed_next = 1'b0;
                held_next    = 2'd0;
                release_next = 2'd0;
            end
        end
        else if (pressed_reg && head_scan.button == held_reg)
        begin
            release_next = 2'd0;
            // Held long enough: report and drop the press but keep the button,
            // so the next held scan starts a fresh press and repeats.
            if (hold_time >= {16'd0, timing.long_press_ms})
            begin
                ev_next      = held_reg;
                lp_next      = 1'b1;
                pressed_next = 1'b0;
            end
        end
        else if (pressed_reg && head_scan.button != 2'd0)
        begin
            ev_next      = held_reg;
            ab_next      = 1'b1;
            pressed_next = 1'b0;
            release_next = 2'd0;
            held_next    = 2'd0;
        end

        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pressed_reg      <= 1'b0;
            held_reg         <= 2'd0;
            start_reg        <= 32'd0;
            release_reg      <= 2'd0;
            click_time_reg   <= 32'd0;
            click_button_reg <= 2'd0;
            tally_reg        <= 2'd0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                pressed_reg      <= pressed_next;
                held_reg         <= held_next;
                start_reg        <= start_next;
                release_reg      <= release_next;
                click_time_reg   <= click_time_next;
                click_button_reg <= click_button_next;
                tally_reg        <= tally_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            ev_reg <= ev_next;
            sp_reg <= sp_next;
            lp_reg <= lp_next;
            dc_reg <= dc_next;
            ab_reg <= ab_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign event_button  = ev_reg;
    assign short_press   = sp_reg;
    assign long_press    = lp_reg;
    assign double_click  = dc_reg;
    assign press_aborted = ab_reg;

endmodule
